// ===== hdl/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg : shared types and constants for the 3x3 matrix inverse
// Element widths, internal datapath widths and the side-band struct that
// rides along the divider stages.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int N_ELEM        = 9;     // matrix elements per transaction
	localparam int ELEM_W        = 32;    // element and result width
	localparam int ADJ_W         = 65;    // signed 2x2 cofactor
	localparam int DET_W         = 98;    // signed exact determinant
	localparam int DMAG_W        = 97;    // determinant magnitude
	localparam int AMAG_W        = 65;    // cofactor magnitude
	localparam int QB            = 33;    // quotient bits kept below overflow
	localparam int REM_W         = DMAG_W + QB + 1; // divider remainder
	localparam int THR_W         = 31;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	typedef struct packed {
		logic                singular;
		logic [ELEM_W-1:0]   det;      // rounded, saturated determinant
		logic [N_ELEM-1:0]   neg;      // result sign per element
	} side_t;

endpackage

// ===== hdl/m3i_cofactor.sv =====
// ----------------------------------------------------------------------------
// m3i_cofactor : element products and adjugate entries
// Stage 1 forms the 18 cofactor products, stage 2 the nine differences.
// ----------------------------------------------------------------------------
module m3i_cofactor (
	input  logic                                  clk,
	input  logic [1:0]                            en,
	input  logic signed [m3i_pkg::ELEM_W-1:0]     a_i    [m3i_pkg::N_ELEM],
	output logic signed [m3i_pkg::ADJ_W-1:0]      adj_s2 [m3i_pkg::N_ELEM],
	output logic signed [m3i_pkg::ELEM_W-1:0]     row_s2 [3]
);

	// adj[e] = a[CP]*a[CQ] - a[CR]*a[CS]
	localparam int CP [m3i_pkg::N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int CQ [m3i_pkg::N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int CR [m3i_pkg::N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int CS [m3i_pkg::N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	logic signed [2*m3i_pkg::ELEM_W-1:0] pp_s1 [m3i_pkg::N_ELEM];
	logic signed [2*m3i_pkg::ELEM_W-1:0] pm_s1 [m3i_pkg::N_ELEM];
	logic signed [m3i_pkg::ELEM_W-1:0]   row_s1 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int e = 0; e < m3i_pkg::N_ELEM; e++) begin
				pp_s1[e] <= a_i[CP[e]] * a_i[CQ[e]];
				pm_s1[e] <= a_i[CR[e]] * a_i[CS[e]];
			end
			for (int r = 0; r < 3; r++) begin
				row_s1[r] <= a_i[r];
			end
		end
		if (en[1]) begin
			for (int e = 0; e < m3i_pkg::N_ELEM; e++) begin
				adj_s2[e] <= m3i_pkg::ADJ_W'(pp_s1[e]) - m3i_pkg::ADJ_W'(pm_s1[e]);
			end
			row_s2 <= row_s1;
		end
	end

endmodule

// ===== hdl/m3i_det.sv =====
// ----------------------------------------------------------------------------
// m3i_det : determinant, singular test and divider setup
// s3 split products, s4 exact determinant, s5 rounding and magnitudes,
// s6 threshold compare, saturation and numerators.
// ----------------------------------------------------------------------------
module m3i_det #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic [3:0]                           en,
	input  logic signed [m3i_pkg::ADJ_W-1:0]     adj_i [m3i_pkg::N_ELEM],
	input  logic signed [m3i_pkg::ELEM_W-1:0]    row_i [3],
	input  logic [m3i_pkg::THR_W-1:0]            thr_i,
	output logic [m3i_pkg::REM_W-1:0]            rem_s6 [m3i_pkg::N_ELEM],
	output logic [m3i_pkg::DMAG_W-1:0]           d_s6,
	output m3i_pkg::side_t                       side_s6
);

	localparam int PW  = m3i_pkg::ELEM_W + 33;     // split product width
	localparam int QW  = m3i_pkg::DET_W + 1;        // rounding width
	localparam int SH  = 2 * FRAC_BITS;
	localparam logic signed [QW-1:0] HALF = QW'(1) <<< (SH - 1);
	localparam logic signed [QW-1:0] SAT_HI = QW'(32'sh7fffffff);
	localparam logic signed [QW-1:0] SAT_LO = -(QW'(1) <<< 31);

	logic signed [PW-1:0]                plo_s3 [3];
	logic signed [PW-1:0]                phi_s3 [3];
	logic signed [m3i_pkg::ADJ_W-1:0]    adj_s3 [m3i_pkg::N_ELEM];
	logic signed [m3i_pkg::DET_W-1:0]    det_s4;
	logic signed [m3i_pkg::ADJ_W-1:0]    adj_s4 [m3i_pkg::N_ELEM];
	logic signed [QW-1:0]                detq_s5;
	logic                                zero_s5;
	logic [m3i_pkg::DMAG_W-1:0]          dmag_s5;
	logic [m3i_pkg::AMAG_W-1:0]          amag_s5 [m3i_pkg::N_ELEM];
	logic [m3i_pkg::N_ELEM-1:0]          neg_s5;

	logic signed [m3i_pkg::DET_W-1:0]    det_sum;
	logic signed [QW-1:0]                det_ext;
	logic [QW-1:0]                       qmag;

	always_comb begin
		det_sum = '0;
		for (int r = 0; r < 3; r++) begin
			det_sum = det_sum + (m3i_pkg::DET_W'(phi_s3[r]) <<< 32)
				+ m3i_pkg::DET_W'(plo_s3[r]);
		end
		det_ext = QW'(det_s4);
		qmag    = detq_s5[QW-1] ? QW'(-detq_s5) : QW'(detq_s5);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int r = 0; r < 3; r++) begin
				plo_s3[r] <= row_i[r] * $signed({1'b0, adj_i[3*r][31:0]});
				phi_s3[r] <= row_i[r] * $signed(adj_i[3*r][m3i_pkg::ADJ_W-1:32]);
			end
			adj_s3 <= adj_i;
		end
		if (en[1]) begin
			det_s4 <= det_sum;
			adj_s4 <= adj_s3;
		end
		if (en[2]) begin
			detq_s5 <= (det_ext + HALF) >>> SH;
			zero_s5 <= (det_s4 == '0);
			dmag_s5 <= det_s4[m3i_pkg::DET_W-1] ? m3i_pkg::DMAG_W'(-det_s4)
				: m3i_pkg::DMAG_W'(det_s4);
			for (int e = 0; e < m3i_pkg::N_ELEM; e++) begin
				amag_s5[e] <= adj_s4[e][m3i_pkg::ADJ_W-1] ? m3i_pkg::AMAG_W'(-adj_s4[e])
					: m3i_pkg::AMAG_W'(adj_s4[e]);
				neg_s5[e]  <= adj_s4[e][m3i_pkg::ADJ_W-1] ^ det_s4[m3i_pkg::DET_W-1];
			end
		end
		if (en[3]) begin
			side_s6.singular <= zero_s5 || (qmag < QW'(thr_i));
			if (detq_s5 > SAT_HI)
				side_s6.det <= 32'h7fffffff;
			else if (detq_s5 < SAT_LO)
				side_s6.det <= 32'h80000000;
			else
				side_s6.det <= detq_s5[m3i_pkg::ELEM_W-1:0];
			side_s6.neg <= neg_s5;
			d_s6        <= dmag_s5;
			for (int e = 0; e < m3i_pkg::N_ELEM; e++) begin
				rem_s6[e] <= (m3i_pkg::REM_W'(amag_s5[e]) << SH)
					+ m3i_pkg::REM_W'(dmag_s5 >> 1);
			end
		end
	end

endmodule

// ===== hdl/m3i_div_step.sv =====
// ----------------------------------------------------------------------------
// m3i_div_step : one restoring-division stage for all nine elements
// K below the quotient width resolves quotient bit K; K equal to it only
// flags a quotient too large for any unsaturated result.
// ----------------------------------------------------------------------------
module m3i_div_step #(
	parameter int K = 0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [m3i_pkg::REM_W-1:0]         rem_i [m3i_pkg::N_ELEM],
	input  logic [m3i_pkg::QB-1:0]            q_i   [m3i_pkg::N_ELEM],
	input  logic [m3i_pkg::N_ELEM-1:0]        ovf_i,
	input  logic [m3i_pkg::DMAG_W-1:0]        d_i,
	input  m3i_pkg::side_t                    side_i,
	output logic [m3i_pkg::REM_W-1:0]         rem_s [m3i_pkg::N_ELEM],
	output logic [m3i_pkg::QB-1:0]            q_s   [m3i_pkg::N_ELEM],
	output logic [m3i_pkg::N_ELEM-1:0]        ovf_s,
	output logic [m3i_pkg::DMAG_W-1:0]        d_s,
	output m3i_pkg::side_t                    side_s
);

	logic [m3i_pkg::REM_W-1:0] dsh;
	logic [m3i_pkg::N_ELEM-1:0] ge;

	always_comb begin
		dsh = m3i_pkg::REM_W'(d_i) << K;
		for (int e = 0; e < m3i_pkg::N_ELEM; e++) begin
			ge[e] = (rem_i[e] >= dsh);
		end
	end

	generate
		if (K >= m3i_pkg::QB) begin : g_ovf
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s <= rem_i;
					q_s   <= q_i;
					ovf_s <= ovf_i | ge;
				end
			end
		end else begin : g_bit
			always_ff @(posedge clk) begin
				if (en) begin
					for (int e = 0; e < m3i_pkg::N_ELEM; e++) begin
						rem_s[e] <= ge[e] ? rem_i[e] - dsh : rem_i[e];
						q_s[e]   <= q_i[e] | (m3i_pkg::QB'(ge[e]) << K);
					end
					ovf_s <= ovf_i;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			d_s    <= d_i;
			side_s <= side_i;
		end
	end

endmodule

// ===== hdl/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse : pipelined 3x3 fixed-point matrix inverse
// Adjugate over exact determinant, rounded and saturated to 32 bits.
// ----------------------------------------------------------------------------
// One matrix per clock goes in and one result per clock comes out while the
// output is not stalled; the result is held in the output register.
// Two stages form the cofactors, four the determinant and divider setup,
// 34 a restoring divider shared by the nine elements (overflow check, then
// one quotient bit per stage), and the last the output register. Every
// stage has its own valid bit and advances when a stage at or after it is
// empty or the output is taken, so an output stall squeezes out bubbles.
// Elements are signed Q(32-FRAC_BITS).FRAC_BITS. singular (in m_tuser) is
// set when the rounded determinant magnitude is below det_threshold or the
// determinant is exactly zero; the inverse is then all zero while
// determinant still reports the rounded value. det_threshold resets to 1
// and is meant to be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22 (32 bits each)
	input  logic [287:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// inv_00 .. inv_22 (32 bits each), then determinant (32 bits)
	output logic [319:0] m_tdata,
	// singular
	output logic         m_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_we,
	input  logic [30:0]  cfg_wdata
);

	localparam int NE     = m3i_pkg::N_ELEM;
	localparam int EW     = m3i_pkg::ELEM_W;
	localparam int ST_DIV = 6;                    // first divider stage
	localparam int NDIV   = m3i_pkg::QB + 1;      // overflow stage + bit stages
	localparam int NST    = ST_DIV + NDIV + 1;    // plus output register

	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;
	logic [NST-1:0] nvld;

	logic [m3i_pkg::THR_W-1:0] det_threshold_q;

	// stage enables: a stage moves when it or a later stage has room or m_tready is high
	always_comb begin
		nvld = ~vld_q;
		for (int k = 0; k < NST; k++) begin
			en[k] = m_tready | (|(nvld >> k));
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q           <= '0;
			det_threshold_q <= m3i_pkg::THR_RESET;
		end else begin
			if (en[0])
				vld_q[0] <= s_tvalid;
			for (int k = 1; k < NST; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
			if (cfg_we)
				det_threshold_q <= cfg_wdata;
		end
	end

	// input unpack
	logic signed [EW-1:0] a_in [NE];
	always_comb begin
		for (int e = 0; e < NE; e++) begin
			a_in[e] = $signed(s_tdata[e*EW +: EW]);
		end
	end

	logic signed [m3i_pkg::ADJ_W-1:0]  adj_s2 [NE];
	logic signed [EW-1:0]              row_s2 [3];

	m3i_cofactor u_cof (
		.clk    (clk),
		.en     (en[1:0]),
		.a_i    (a_in),
		.adj_s2 (adj_s2),
		.row_s2 (row_s2)
	);

	// divider chain buses, index 0 feeds the overflow stage
	logic [m3i_pkg::REM_W-1:0]  rem_c  [NDIV+1][NE];
	logic [m3i_pkg::QB-1:0]     q_c    [NDIV+1][NE];
	logic [NE-1:0]              ovf_c  [NDIV+1];
	logic [m3i_pkg::DMAG_W-1:0] d_c    [NDIV+1];
	m3i_pkg::side_t             side_c [NDIV+1];

	m3i_det #(
		.FRAC_BITS (FRAC_BITS)
	) u_det (
		.clk     (clk),
		.en      (en[ST_DIV-1:2]),
		.adj_i   (adj_s2),
		.row_i   (row_s2),
		.thr_i   (det_threshold_q),
		.rem_s6  (rem_c[0]),
		.d_s6    (d_c[0]),
		.side_s6 (side_c[0])
	);

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			q_c[0][e] = '0;
		end
		ovf_c[0] = '0;
	end

	generate
		for (genvar j = 0; j < NDIV; j++) begin : g_div
			m3i_div_step #(
				.K (m3i_pkg::QB - j)
			) u_step (
				.clk    (clk),
				.en     (en[ST_DIV + j]),
				.rem_i  (rem_c[j]),
				.q_i    (q_c[j]),
				.ovf_i  (ovf_c[j]),
				.d_i    (d_c[j]),
				.side_i (side_c[j]),
				.rem_s  (rem_c[j+1]),
				.q_s    (q_c[j+1]),
				.ovf_s  (ovf_c[j+1]),
				.d_s    (d_c[j+1]),
				.side_s (side_c[j+1])
			);
		end
	endgenerate

	// final sign, saturation and singular masking
	localparam logic [m3i_pkg::QB-1:0] POS_MAX = m3i_pkg::QB'(32'h7fffffff);
	localparam logic [m3i_pkg::QB-1:0] NEG_MAX = m3i_pkg::QB'(32'h80000000);

	logic [EW-1:0]        inv_nx [NE];
	logic [NE*EW-1:0]     inv_s41;
	logic [EW-1:0]        det_s41;
	logic                 sing_s41;
	m3i_pkg::side_t       side_f;

	always_comb begin
		side_f = side_c[NDIV];
		for (int e = 0; e < NE; e++) begin
			if (side_f.singular)
				inv_nx[e] = '0;
			else if (!side_f.neg[e])
				inv_nx[e] = (ovf_c[NDIV][e] || q_c[NDIV][e] > POS_MAX) ? 32'h7fffffff
					: q_c[NDIV][e][EW-1:0];
			else
				inv_nx[e] = (ovf_c[NDIV][e] || q_c[NDIV][e] > NEG_MAX) ? 32'h80000000
					: EW'(-q_c[NDIV][e][EW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			for (int e = 0; e < NE; e++) begin
				inv_s41[e*EW +: EW] <= inv_nx[e];
			end
			det_s41  <= side_f.det;
			sing_s41 <= side_f.singular;
		end
	end

	assign m_tdata = {det_s41, inv_s41};
	assign m_tuser = sing_s41;

endmodule
